// ===== sv/mra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_pkg
// Shared widths and constants for the maximal rectangle area block.
// ----------------------------------------------------------------------------
package mra_pkg;

	localparam int AREA_W = 21;
	localparam logic [AREA_W-1:0] AREA_MAX = '1;

	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] COLUMNS_RESET = 11'd1024;

endpackage

// ===== sv/mra_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_in_if / mra_out_if
// Valid/ready channels: matrix cells in, best area out.
// ----------------------------------------------------------------------------
interface mra_in_if ();
	logic valid;
	logic ready;
	logic cell_req;
	logic matrix_end;

	modport source (output valid, cell_req, matrix_end, input ready);
	modport sink (input valid, cell_req, matrix_end, output ready);
endinterface

interface mra_out_if import mra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] best_area;

	modport source (output valid, best_area, input ready);
	modport sink (input valid, best_area, output ready);
endinterface

// ===== sv/mra_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/mra_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_score
// Rectangle scorer: registered multiply, then saturate and keep the maximum.
// ----------------------------------------------------------------------------
module mra_score import mra_pkg::*; #(
	parameter int HW = 11,
	parameter int EW = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req,
	input  logic [HW-1:0]     height,
	input  logic [EW-1:0]     width,
	input  logic              clear,
	output logic [AREA_W-1:0] largest
);

	localparam int PW = HW + EW;

	logic              req_s1;
	logic [PW-1:0]     prod_s1;
	logic [AREA_W-1:0] sat;
	logic [AREA_W-1:0] largest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= 1'b0;
		end else begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(height) * PW'(width);
	end

	always_comb begin
		if (32'(prod_s1) > 32'(AREA_MAX)) begin
			sat = AREA_MAX;
		end else begin
			sat = AREA_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q <= '0;
		end else if (clear) begin
			largest_q <= '0;
		end else if (req_s1 && sat > largest_q) begin
			largest_q <= sat;
		end
	end

	assign largest = largest_q;

endmodule

// ===== sv/maximal_rectangle_area.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maximal_rectangle_area
// Largest all-ones rectangle of a binary matrix streamed in row-major order.
// ----------------------------------------------------------------------------
// Flow: one cell at a time; a new cell is taken only in the idle state, after
//   the previous cell's update, its pops and push, and any row-end flush; at
//   matrix end the block waits while the previous result is still unaccepted.
// Output: best_area is loaded into the output word in the hand-over state.
// Reset: all control and the best area clear at once; column heights are
//   masked by a fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module maximal_rectangle_area import mra_pkg::*; #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	mra_in_if.sink           cells,
	mra_out_if.source        result,
	input  logic             cfg_wen,
	input  logic [CFG_W-1:0] cfg_wdata
);

	// index, edge/depth, height and stack word widths
	localparam int IW = $clog2(MAX_COLUMNS);
	localparam int EW = IW + 1;
	localparam int HW = $clog2(MAX_ROWS + 1);
	localparam int SW = IW + HW;

	typedef enum logic [2:0] {
		ST_IDLE,   // waiting for a cell
		ST_LOAD,   // height read back, update and write
		ST_CHECK,  // compare stack top against limit
		ST_POPRD,  // bar below the top has arrived: score and pop
		ST_PUSH,   // push the current column, decide on row end
		ST_DONE    // hand over the best area
	} state_t;

	state_t            state_q;
	logic              last_q;
	logic              cell_q;
	logic              flush_q;    // popping with limit zero at row end
	logic [IW-1:0]     pos_q;
	logic [EW-1:0]     fill_q;     // columns written in this matrix
	logic [EW-1:0]     depth_q;    // stack depth, top held in registers
	logic [IW-1:0]     top_idx_q;
	logic [HW-1:0]     top_h_q;
	logic [HW-1:0]     limit_q;
	logic [EW-1:0]     edge_q;
	logic [CFG_W-1:0]  cols_q;
	logic              out_valid_q;
	logic [AREA_W-1:0] out_area_q;

	// memories
	logic              h_we;
	logic [HW-1:0]     h_wdata;
	logic [HW-1:0]     h_rdata;
	logic              s_we;
	logic [IW-1:0]     s_waddr;
	logic [IW-1:0]     s_raddr;
	logic [SW-1:0]     s_rdata;
	logic [IW-1:0]     below_idx;
	logic [HW-1:0]     below_h;

	// scorer
	logic              sc_req;
	logic [EW-1:0]     sc_width;
	logic              sc_clear;
	logic [AREA_W-1:0] largest;

	// combinational helpers
	logic [HW-1:0]     h_old;
	logic [EW-1:0]     cols_eff;
	logic              pop;
	logic              row_end;
	logic              out_free;

	// row width clamped to 1..MAX_COLUMNS
	always_comb begin
		if (cols_q == '0) begin
			cols_eff = EW'(1);
		end else if (32'(cols_q) > 32'(MAX_COLUMNS)) begin
			cols_eff = EW'(MAX_COLUMNS);
		end else begin
			cols_eff = EW'(cols_q);
		end
	end

	// a column not yet written in this matrix reads as zero
	assign h_old = (EW'(pos_q) < fill_q) ? h_rdata : '0;

	always_comb begin
		if (!cell_q) begin
			h_wdata = '0;
		end else if (32'(h_old) < 32'(MAX_ROWS)) begin
			h_wdata = h_old + HW'(1);
		end else begin
			h_wdata = HW'(MAX_ROWS);
		end
	end

	assign h_we = (state_q == ST_LOAD);

	mra_ram #(
		.WIDTH (HW),
		.DEPTH (MAX_COLUMNS)
	) u_height (
		.clk   (clk),
		.we    (h_we),
		.waddr (pos_q),
		.wdata (h_wdata),
		.raddr (pos_q),
		.rdata (h_rdata)
	);

	// stack memory holds every bar below the top; next-below is at depth-2
	assign s_raddr = IW'(depth_q - EW'(2));
	assign s_waddr = IW'(depth_q - EW'(1));
	assign s_we    = (state_q == ST_PUSH) && (depth_q != '0);
	assign {below_idx, below_h} = s_rdata;

	mra_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_COLUMNS)
	) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata ({top_idx_q, top_h_q}),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign pop      = (depth_q != '0) && (top_h_q > limit_q);
	assign row_end  = last_q || ((EW'(pos_q) + EW'(1)) >= cols_eff);
	assign out_free = !out_valid_q || result.ready;

	// score the popped bar: full width when it was the bottom bar
	always_comb begin
		sc_req   = 1'b0;
		sc_width = edge_q;
		if (state_q == ST_CHECK && pop && depth_q == EW'(1)) begin
			sc_req = 1'b1;
		end else if (state_q == ST_POPRD) begin
			sc_req   = 1'b1;
			sc_width = edge_q - EW'(1) - EW'(below_idx);
		end
	end

	assign sc_clear = (state_q == ST_DONE) && out_free;

	mra_score #(
		.HW (HW),
		.EW (EW)
	) u_score (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sc_req),
		.height  (top_h_q),
		.width   (sc_width),
		.clear   (sc_clear),
		.largest (largest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLUMNS_RESET;
		end else if (cfg_wen) begin
			cols_q <= cfg_wdata;
		end
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			cell_q      <= 1'b0;
			flush_q     <= 1'b0;
			pos_q       <= '0;
			fill_q      <= '0;
			depth_q     <= '0;
			top_idx_q   <= '0;
			top_h_q     <= '0;
			limit_q     <= '0;
			edge_q      <= '0;
			out_valid_q <= 1'b0;
			out_area_q  <= '0;
		end else begin
			// the hand-over state reloads the output word itself
			if (out_valid_q && result.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cells.valid) begin
						cell_q  <= cells.cell_req;
						last_q  <= cells.matrix_end;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (EW'(pos_q) == fill_q) begin
						fill_q <= fill_q + EW'(1);
					end
					limit_q <= h_wdata;
					edge_q  <= EW'(pos_q);
					flush_q <= 1'b0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (pop) begin
						if (depth_q == EW'(1)) begin
							depth_q <= '0;
						end else begin
							state_q <= ST_POPRD;
						end
					end else if (!flush_q) begin
						state_q <= ST_PUSH;
					end else begin
						depth_q <= '0;
						pos_q   <= '0;
						state_q <= last_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_POPRD: begin
					top_idx_q <= below_idx;
					top_h_q   <= below_h;
					depth_q   <= depth_q - EW'(1);
					state_q   <= ST_CHECK;
				end
				ST_PUSH: begin
					top_idx_q <= pos_q;
					top_h_q   <= limit_q;
					depth_q   <= depth_q + EW'(1);
					if (row_end) begin
						flush_q <= 1'b1;
						limit_q <= '0;
						edge_q  <= EW'(pos_q) + EW'(1);
						state_q <= ST_CHECK;
					end else begin
						pos_q   <= pos_q + IW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_area_q  <= largest;
						fill_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cells.ready      = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.best_area = out_area_q;

endmodule
